// ===== rtl/core/wavhdr_pkg.sv =====
// shared constants and types for the wav header parser
`default_nettype none

package wavhdr_pkg;

  // chunk and form tags, little-endian as assembled from the byte stream
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;

  localparam logic [15:0] PCM_TAG    = 16'd1;
  localparam logic [15:0] EIGHT_BITS = 16'd8;
  localparam logic [15:0] MONO       = 16'd1;
  localparam logic [31:0] FMT_BYTES  = 32'd16;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF   = 3'd1;
  localparam logic [2:0] ST_NOT_PCM    = 3'd2;
  localparam logic [2:0] ST_DATA_FIRST = 3'd3;
  localparam logic [2:0] ST_NO_DATA    = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;

  // sample format codes
  localparam logic [1:0] SF_MONO8    = 2'd0;
  localparam logic [1:0] SF_MONO16   = 2'd1;
  localparam logic [1:0] SF_STEREO8  = 2'd2;
  localparam logic [1:0] SF_STEREO16 = 2'd3;

  // default depth of the byte queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one queued item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } q_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/wavhdr_if.sv =====
// handshake channels for file bytes in and parse results out
`default_nettype none

interface wavhdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wavhdr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  sample_format;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic [31:0] sample_rate;
  logic [31:0] payload_size;

  modport source (output valid, output status, output sample_format,
                  output channel_count, output sample_bits, output sample_rate,
                  output payload_size, input ready);
  modport sink (input valid, input status, input sample_format,
                input channel_count, input sample_bits, input sample_rate,
                input payload_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wav_header_parser_core.sv =====
// wav header parser: one byte per cycle, at most one result per file
// throughput: one file byte per cycle while the result slot is empty or draining
// the deciding byte passes through the byte queue before the result is registered in the result slot
// the back end holds while the result slot is full; the byte queue absorbs it
// reset: empties the queue and the result slot, parser waits for a riff tag
`default_nettype none

module wav_header_parser_core #(
  parameter int QUEUE_DEPTH = wavhdr_pkg::QUEUE_DEPTH
) (
  input wire logic     clk,
  input wire logic     rst,
  wavhdr_in_if.sink    in_ch,
  wavhdr_out_if.source out_ch
);

  wavhdr_pkg::q_head_t head;
  logic                pop;

  // byte intake and queue
  wavhdr_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // chunk walker and result slot
  wavhdr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/wavhdr_front.sv =====
// front end: accepts file bytes and queues them for the parser
`default_nettype none

module wavhdr_front #(
  parameter int DEPTH = wavhdr_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  wavhdr_in_if.sink          in_ch,
  output wavhdr_pkg::q_head_t head,
  input  wire logic          pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL    = CW'(DEPTH);

  wavhdr_pkg::q_item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          take;

  assign in_ch.ready = (count != FULL);
  assign push = in_ch.valid && in_ch.ready;
  assign take = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].data_byte <= in_ch.data_byte;
      slots[wr_ptr].last_byte <= in_ch.last_byte;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wavhdr_back.sv =====
// back end: riff/wave chunk walker with a registered result slot
`default_nettype none

module wavhdr_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wavhdr_pkg::q_head_t head,
  output logic                     pop,
  wavhdr_out_if.source             out_ch
);

  // parse phases
  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_WAVE = 3'd2;
  localparam logic [2:0] PH_CTAG = 3'd3;
  localparam logic [2:0] PH_CLEN = 3'd4;
  localparam logic [2:0] PH_FMT  = 3'd5;
  localparam logic [2:0] PH_SKIP = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic        seen, seen_next;
  logic [31:0] word, word_next;
  logic [31:0] tag, tag_next;
  logic [31:0] len, len_next;
  logic [15:0] ftag, ftag_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] bits, bits_next;

  logic        fire;
  logic        res_ok;
  logic [2:0]  res_status;
  logic [31:0] len_dec;
  logic [31:0] asm_word;
  logic [7:0]  b;

  // item is taken when the result slot is free or being drained
  assign pop = head.valid && (!out_ch.valid || out_ch.ready);
  assign b   = head.item.data_byte;
  assign asm_word = {b, word[31:8]};
  assign len_dec  = len - 32'd1;

  // one byte step of the chunk walker
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    seen_next  = seen;
    word_next  = word;
    tag_next   = tag;
    len_next   = len;
    ftag_next  = ftag;
    chans_next = chans;
    rate_next  = rate;
    bits_next  = bits;
    fire       = 1'b0;
    res_ok     = 1'b0;
    res_status = wavhdr_pkg::ST_OK;

    if (phase == PH_SKIP) begin
      len_next = len_dec;
      if (len_dec == '0) begin
        phase_next = PH_CTAG;
        pos_next   = '0;
      end
    end else if (phase != PH_DONE) begin
      word_next = asm_word;
      pos_next  = pos + 4'd1;
      unique case (phase)
        PH_RIFF: begin
          if (pos == 4'd3) begin
            tag_next   = asm_word;
            phase_next = PH_SIZE;
            pos_next   = '0;
          end
        end
        PH_SIZE: begin
          if (pos == 4'd3) begin
            phase_next = PH_WAVE;
            pos_next   = '0;
          end
        end
        PH_WAVE: begin
          if (pos == 4'd3) begin
            pos_next = '0;
            if (tag != wavhdr_pkg::TAG_RIFF || asm_word != wavhdr_pkg::TAG_WAVE) begin
              fire       = 1'b1;
              res_status = wavhdr_pkg::ST_NOT_RIFF;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_CTAG;
            end
          end
        end
        PH_CTAG: begin
          if (pos == 4'd3) begin
            tag_next   = asm_word;
            phase_next = PH_CLEN;
            pos_next   = '0;
          end
        end
        PH_CLEN: begin
          if (pos == 4'd3) begin
            len_next = asm_word;
            pos_next = '0;
            if (tag == wavhdr_pkg::TAG_FMT) begin
              phase_next = PH_FMT;
            end else if (tag == wavhdr_pkg::TAG_DATA) begin
              fire       = 1'b1;
              res_ok     = seen;
              res_status = seen ? wavhdr_pkg::ST_OK : wavhdr_pkg::ST_DATA_FIRST;
              phase_next = PH_DONE;
            end else if (asm_word == '0) begin
              phase_next = PH_CTAG;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (pos == 4'd1) begin
            ftag_next = asm_word[31:16];
          end else if (pos == 4'd3) begin
            chans_next = asm_word[31:16];
          end else if (pos == 4'd7) begin
            rate_next = asm_word;
          end else if (pos == 4'd15) begin
            bits_next = asm_word[31:16];
            seen_next = 1'b1;
            pos_next  = '0;
            if (ftag != wavhdr_pkg::PCM_TAG) begin
              fire       = 1'b1;
              res_status = wavhdr_pkg::ST_NOT_PCM;
              phase_next = PH_DONE;
            end else if (len > wavhdr_pkg::FMT_BYTES) begin
              len_next   = len - wavhdr_pkg::FMT_BYTES;
              phase_next = PH_SKIP;
            end else begin
              phase_next = PH_CTAG;
            end
          end
        end
        default: begin
          phase_next = PH_DONE;
          pos_next   = '0;
        end
      endcase
    end

    // end of file: error if nothing given yet, then rearm
    if (head.item.last_byte) begin
      if (!fire && phase_next != PH_DONE) begin
        fire       = 1'b1;
        res_status = (phase_next == PH_SKIP || (phase_next == PH_CTAG && pos_next == '0))
                     ? wavhdr_pkg::ST_NO_DATA : wavhdr_pkg::ST_TRUNCATED;
      end
      phase_next = PH_RIFF;
      pos_next   = '0;
      seen_next  = 1'b0;
    end
  end

  // parser control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      pos   <= '0;
      seen  <= 1'b0;
    end else if (pop) begin
      phase <= phase_next;
      pos   <= pos_next;
      seen  <= seen_next;
    end
  end

  // parser data registers
  always_ff @(posedge clk) begin
    if (pop) begin
      word  <= word_next;
      tag   <= tag_next;
      len   <= len_next;
      ftag  <= ftag_next;
      chans <= chans_next;
      rate  <= rate_next;
      bits  <= bits_next;
    end
  end

  // result slot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pop && fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // result slot payload
  always_ff @(posedge clk) begin
    if (pop && fire) begin
      out_ch.status <= res_status;
      if (res_ok) begin
        if (chans == wavhdr_pkg::MONO) begin
          out_ch.sample_format <= (bits == wavhdr_pkg::EIGHT_BITS)
                                  ? wavhdr_pkg::SF_MONO8 : wavhdr_pkg::SF_MONO16;
        end else begin
          out_ch.sample_format <= (bits == wavhdr_pkg::EIGHT_BITS)
                                  ? wavhdr_pkg::SF_STEREO8 : wavhdr_pkg::SF_STEREO16;
        end
        out_ch.channel_count <= chans;
        out_ch.sample_bits   <= bits;
        out_ch.sample_rate   <= rate;
        out_ch.payload_size  <= len_next;
      end else begin
        out_ch.sample_format <= wavhdr_pkg::SF_MONO8;
        out_ch.channel_count <= '0;
        out_ch.sample_bits   <= '0;
        out_ch.sample_rate   <= '0;
        out_ch.payload_size  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/wav_header_parser_core_tb.sv =====
// testbench for the wav header parser: byte stream in, one checked header result per file
`timescale 1ns / 100ps

module wav_header_parser_core_tb;

  localparam int STIM_BYTES  = 1300;
  localparam int MIN_FILES   = 20;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  // parser walk through the file
  localparam logic [2:0] PH_RIFF_TAG  = 3'd0;
  localparam logic [2:0] PH_RIFF_SIZE = 3'd1;
  localparam logic [2:0] PH_FORM      = 3'd2;
  localparam logic [2:0] PH_CHUNK_TAG = 3'd3;
  localparam logic [2:0] PH_CHUNK_LEN = 3'd4;
  localparam logic [2:0] PH_FMT_BODY  = 3'd5;
  localparam logic [2:0] PH_SKIP      = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  sample_format;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] sample_rate;
    logic [31:0] payload_size;
  } header_result_t;

  // shape of one generated file
  typedef struct {
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] fmt_len;
    logic [31:0] data_len;
    int          junk_before;
    int          junk_after;
    int          payload;
    int          cut;
    int          noise_len;
    bit          second_fmt;
    bit          data_first;
    bit          bad_form;
  } wav_plan_t;

  // mirror of the parser plus the queue of expected header results
  class header_scoreboard;
    logic [2:0]     phase;
    logic [31:0]    pos;
    logic [31:0]    word;
    logic [31:0]    tag;
    logic [31:0]    len;
    bit             fmt_seen;
    logic [15:0]    fmt_tag;
    logic [15:0]    chans;
    logic [31:0]    rate;
    logic [15:0]    bits;
    bit             outcome;
    header_result_t expected_headers[$];
    int             errors;
    int             bytes_seen;
    int             files_seen;
    int             results_checked;
    int             status_hits[8];

    function new();
      rearm();
    endfunction

    function void rearm();
      phase    = PH_RIFF_TAG;
      pos      = '0;
      word     = '0;
      tag      = '0;
      len      = '0;
      fmt_seen = 1'b0;
      fmt_tag  = '0;
      chans    = '0;
      rate     = '0;
      bits     = '0;
      outcome  = 1'b0;
    endfunction

    function void enter(logic [2:0] ph);
      phase = ph;
      pos   = '0;
    endfunction

    // queue one result; error results carry zero fields
    function void post(logic [2:0] st, bit ok);
      header_result_t r;
      r = '0;
      r.status = st;
      if (ok) begin
        if (chans == wavhdr_pkg::MONO)
          r.sample_format = (bits == wavhdr_pkg::EIGHT_BITS)
                            ? wavhdr_pkg::SF_MONO8 : wavhdr_pkg::SF_MONO16;
        else
          r.sample_format = (bits == wavhdr_pkg::EIGHT_BITS)
                            ? wavhdr_pkg::SF_STEREO8 : wavhdr_pkg::SF_STEREO16;
        r.channel_count = chans;
        r.sample_bits   = bits;
        r.sample_rate   = rate;
        r.payload_size  = len;
      end
      expected_headers.push_back(r);
      status_hits[st]++;
      outcome = 1'b1;
      phase   = PH_DONE;
    endfunction

    // one file byte through the parser, returns 1 when it decides the result
    function bit step_byte(logic [7:0] b);
      logic [31:0] idx;
      if (phase == PH_DONE) return 1'b0;
      if (phase == PH_SKIP) begin
        len = len - 1;
        if (len == 0) enter(PH_CHUNK_TAG);
        return 1'b0;
      end
      word = {b, word[31:8]};
      idx  = pos;
      pos  = pos + 1;
      case (phase)
        PH_RIFF_TAG: if (idx == 3) begin
          tag = word;
          enter(PH_RIFF_SIZE);
        end
        PH_RIFF_SIZE: if (idx == 3) enter(PH_FORM);
        PH_FORM: if (idx == 3) begin
          if (tag != wavhdr_pkg::TAG_RIFF || word != wavhdr_pkg::TAG_WAVE) begin
            post(wavhdr_pkg::ST_NOT_RIFF, 1'b0);
            return 1'b1;
          end
          enter(PH_CHUNK_TAG);
        end
        PH_CHUNK_TAG: if (idx == 3) begin
          tag = word;
          enter(PH_CHUNK_LEN);
        end
        PH_CHUNK_LEN: if (idx == 3) begin
          len = word;
          if (tag == wavhdr_pkg::TAG_FMT) enter(PH_FMT_BODY);
          else if (tag == wavhdr_pkg::TAG_DATA) begin
            post(fmt_seen ? wavhdr_pkg::ST_OK : wavhdr_pkg::ST_DATA_FIRST, fmt_seen);
            return 1'b1;
          end else if (len == 0) enter(PH_CHUNK_TAG);
          else enter(PH_SKIP);
        end
        PH_FMT_BODY: case (idx)
          1: fmt_tag = word[31:16];
          3: chans = word[31:16];
          7: rate = word;
          15: begin
            bits     = word[31:16];
            fmt_seen = 1'b1;
            if (fmt_tag != wavhdr_pkg::PCM_TAG) begin
              post(wavhdr_pkg::ST_NOT_PCM, 1'b0);
              return 1'b1;
            end
            if (len > wavhdr_pkg::FMT_BYTES) begin
              len = len - wavhdr_pkg::FMT_BYTES;
              enter(PH_SKIP);
            end else enter(PH_CHUNK_TAG);
          end
          default: ;
        endcase
        default: enter(PH_DONE);
      endcase
      return 1'b0;
    endfunction

    // accepted input byte; the final byte forces a result and rearms
    function void note_byte(logic [7:0] b, logic lst);
      void'(step_byte(b));
      bytes_seen++;
      if (lst) begin
        if (!outcome) begin
          if (phase == PH_SKIP || (phase == PH_CHUNK_TAG && pos == 0))
            post(wavhdr_pkg::ST_NO_DATA, 1'b0);
          else post(wavhdr_pkg::ST_TRUNCATED, 1'b0);
        end
        files_seen++;
        rearm();
      end
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(header_result_t got);
      header_result_t want;
      if (expected_headers.size() == 0) begin
        $error("result with status %0d arrived with no result expected", got.status);
        errors++;
        return;
      end
      want = expected_headers.pop_front();
      results_checked++;
      match("status", want.status, got.status);
      match("sample_format", want.sample_format, got.sample_format);
      match("channel_count", want.channel_count, got.channel_count);
      match("sample_bits", want.sample_bits, got.sample_bits);
      match("sample_rate", want.sample_rate, got.sample_rate);
      match("payload_size", want.payload_size, got.payload_size);
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  bit   tx_calm;
  bit   rx_calm;
  logic [7:0] file_q[$];
  header_scoreboard board;

  wavhdr_in_if  in_ch();
  wavhdr_out_if out_ch();

  wav_header_parser_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // file assembly helpers
  function automatic void push_le(logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_junk(int count);
    logic [31:0] jtag;
    int          jlen;
    repeat (count) begin
      jtag = $urandom;
      if (jtag == wavhdr_pkg::TAG_FMT || jtag == wavhdr_pkg::TAG_DATA) jtag ^= 32'h1;
      jlen = $urandom_range(0, 6);
      push_le(jtag, 4);
      push_le(jlen, 4);
      repeat (jlen) file_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void add_fmt(logic [15:0] ftag, logic [15:0] ch, logic [15:0] bt,
                                  logic [31:0] rt, logic [31:0] flen);
    push_le(wavhdr_pkg::TAG_FMT, 4);
    push_le(flen, 4);
    push_le(ftag, 2);
    push_le(ch, 2);
    push_le(rt, 4);
    push_le($urandom, 4);
    push_le($urandom, 2);
    push_le(bt, 2);
    if (flen > wavhdr_pkg::FMT_BYTES)
      repeat (flen - wavhdr_pkg::FMT_BYTES) file_q.push_back(8'($urandom));
  endfunction

  function automatic void add_data(wav_plan_t p);
    push_le(wavhdr_pkg::TAG_DATA, 4);
    push_le(p.data_len, 4);
    repeat (p.payload) file_q.push_back(8'($urandom));
  endfunction

  function automatic void build_file(wav_plan_t p);
    int n;
    file_q.delete();
    if (p.noise_len > 0) begin
      repeat (p.noise_len) file_q.push_back(8'($urandom));
      return;
    end
    push_le(wavhdr_pkg::TAG_RIFF, 4);
    push_le($urandom, 4);
    push_le(wavhdr_pkg::TAG_WAVE, 4);
    // corrupt one bit of the riff or wave tag
    if (p.bad_form) begin
      n = $urandom_range(0, 7);
      if (n >= 4) n += 4;
      file_q[n] ^= 8'(1 << $urandom_range(0, 7));
    end
    if (p.data_first) add_data(p);
    add_junk(p.junk_before);
    add_fmt(p.fmt_tag, p.chans, p.bits, p.rate, p.fmt_len);
    if (p.second_fmt)
      add_fmt(wavhdr_pkg::PCM_TAG, 16'($urandom_range(1, 2)),
              $urandom_range(0, 1) ? wavhdr_pkg::EIGHT_BITS : 16'd16,
              $urandom, wavhdr_pkg::FMT_BYTES);
    add_junk(p.junk_after);
    add_data(p);
    if (p.cut > 0) while (file_q.size() > p.cut) void'(file_q.pop_back());
  endfunction

  // clean pcm stereo16 file with nothing extra
  function automatic wav_plan_t base_plan();
    wav_plan_t p;
    p.fmt_tag     = wavhdr_pkg::PCM_TAG;
    p.chans       = 16'd2;
    p.bits        = 16'd16;
    p.rate        = 32'd44100;
    p.fmt_len     = wavhdr_pkg::FMT_BYTES;
    p.data_len    = 32'd1024;
    p.junk_before = 0;
    p.junk_after  = 0;
    p.payload     = 0;
    p.cut         = 0;
    p.noise_len   = 0;
    p.second_fmt  = 1'b0;
    p.data_first  = 1'b0;
    p.bad_form    = 1'b0;
    return p;
  endfunction

  // mostly well-formed files with random content, some broken or noise
  function automatic wav_plan_t random_plan();
    wav_plan_t p;
    p = base_plan();
    if ($urandom_range(0, 9) == 0) begin
      p.noise_len = $urandom_range(1, 24);
      return p;
    end
    p.fmt_tag = ($urandom_range(0, 9) == 0) ? 16'($urandom) : wavhdr_pkg::PCM_TAG;
    case ($urandom_range(0, 3))
      0: p.chans = wavhdr_pkg::MONO;
      1: p.chans = 16'd2;
      default: p.chans = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: p.bits = wavhdr_pkg::EIGHT_BITS;
      1: p.bits = 16'd16;
      default: p.bits = 16'($urandom);
    endcase
    p.rate = $urandom;
    case ($urandom_range(0, 3))
      0: p.fmt_len = $urandom_range(0, 15);
      1: p.fmt_len = wavhdr_pkg::FMT_BYTES + $urandom_range(1, 6);
      default: p.fmt_len = wavhdr_pkg::FMT_BYTES;
    endcase
    p.data_len    = $urandom;
    p.junk_before = $urandom_range(0, 2);
    p.junk_after  = $urandom_range(0, 1);
    p.payload     = $urandom_range(0, 3);
    p.second_fmt  = ($urandom_range(0, 5) == 0);
    p.data_first  = ($urandom_range(0, 11) == 0);
    p.bad_form    = ($urandom_range(0, 11) == 0);
    if ($urandom_range(0, 4) == 0) p.cut = $urandom_range(1, 70);
    return p;
  endfunction

  // one byte through the input handshake
  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    gap = draw_wait(tx_calm);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_byte(b, lst);
  endtask

  task automatic send_file(wav_plan_t p);
    build_file(p);
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // hold the input until every expected result has come out
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // result side with random stalls
  initial begin : result_sink
    int             stall;
    header_result_t got;
    out_ch.ready <= 1'b0;
    rx_calm = 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      got.status        = out_ch.status;
      got.sample_format = out_ch.sample_format;
      got.channel_count = out_ch.channel_count;
      got.sample_bits   = out_ch.sample_bits;
      got.sample_rate   = out_ch.sample_rate;
      got.payload_size  = out_ch.payload_size;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    wav_plan_t p;
    board = new();
    tx_calm = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // mono8 with zero rate and zero payload size
    p = base_plan();
    p.chans = wavhdr_pkg::MONO; p.bits = wavhdr_pkg::EIGHT_BITS;
    p.rate = '0; p.data_len = '0;
    send_file(p);
    // all-ones fields, long fmt chunk with extra bytes, a chunk to skip, trailing payload
    p = base_plan();
    p.chans = 16'hFFFF; p.bits = 16'hFFFF; p.rate = '1; p.data_len = '1;
    p.fmt_len = wavhdr_pkg::FMT_BYTES + 2; p.junk_before = 1; p.payload = 2;
    send_file(p);
    // short fmt chunk length, then a second fmt that overrides it
    p = base_plan();
    p.chans = wavhdr_pkg::MONO; p.bits = 16'd16; p.fmt_len = 32'd4; p.second_fmt = 1'b1;
    send_file(p);
    // data chunk ahead of fmt
    p = base_plan();
    p.bits = wavhdr_pkg::EIGHT_BITS; p.data_first = 1'b1;
    send_file(p);
    // non-pcm format tag
    p = base_plan();
    p.fmt_tag = 16'hFFFE;
    send_file(p);
    // broken riff or wave tag
    p = base_plan();
    p.bad_form = 1'b1;
    send_file(p);
    // file ends inside the fmt chunk body
    p = base_plan();
    p.cut = 22;
    send_file(p);
    // file ends right after the fmt chunk
    p = base_plan();
    p.cut = 36;
    send_file(p);
    // single byte file
    p = base_plan();
    p.noise_len = 1;
    send_file(p);
    wait_for_results();

    // random files
    while (board.bytes_seen < STIM_BYTES || board.files_seen < MIN_FILES) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      send_file(random_plan());
      if ($urandom_range(0, 11) == 0) wait_for_results();
    end

    // drain and settle
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d files, %0d bytes sent, %0d header results checked in %0d cycles",
             board.files_seen, board.bytes_seen, board.results_checked, cycle_count);
    $display("by status: ok %0d, bad form %0d, not pcm %0d, data first %0d, no data %0d, cut %0d",
             board.status_hits[wavhdr_pkg::ST_OK],
             board.status_hits[wavhdr_pkg::ST_NOT_RIFF],
             board.status_hits[wavhdr_pkg::ST_NOT_PCM],
             board.status_hits[wavhdr_pkg::ST_DATA_FIRST],
             board.status_hits[wavhdr_pkg::ST_NO_DATA],
             board.status_hits[wavhdr_pkg::ST_TRUNCATED]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
